### src/lfsc_pkg.sv
// ----------------------------------------------------------------------------
// lfsc_pkg
// Shared constants and types for the letter-filtered substring counter.
// ----------------------------------------------------------------------------
package lfsc_pkg;

    localparam int MAX_PATTERN   = 32;
    localparam int MAX_TEXT      = 1024;
    localparam int CHAR_W        = 8;
    localparam int LEN_W         = 6;
    localparam int WORD_W        = 64;
    localparam int NUM_WORDS     = 4;
    localparam int PAT_W         = NUM_WORDS * WORD_W;
    localparam int CELL_IDX_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SEEN_W        = 6;
    localparam int COUNT_W       = 11;
    localparam int CFG_IDX_W     = 3;
    localparam int COUNT_FIELD_MAX = (1 << COUNT_W) - 1;
    localparam int COUNT_LIMIT   = (MAX_TEXT < COUNT_FIELD_MAX) ? MAX_TEXT : COUNT_FIELD_MAX;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_PATTERN_WORD_0 = 3'd1,
        CFG_PATTERN_WORD_1 = 3'd2,
        CFG_PATTERN_WORD_2 = 3'd3,
        CFG_PATTERN_WORD_3 = 3'd4
    } cfg_index_t;

    typedef logic [PAT_W-1:0] pattern_t;

    // control broadcast to every cell of the window
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

endpackage

### src/lfsc_cell.sv
// ----------------------------------------------------------------------------
// lfsc_cell
// One window position: holds a letter, takes its neighbor's letter on a shift
// and compares the incoming letter against the aligned pattern letter.
// ----------------------------------------------------------------------------
module lfsc_cell
    import lfsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cell_ctrl_t            ctrl,
    input  logic [CELL_IDX_W-1:0] cell_idx,
    input  logic [LEN_W-1:0]      pattern_length,
    input  pattern_t              pattern,
    input  logic [CHAR_W-1:0]     letter_in,
    output logic [CHAR_W-1:0]     letter_out,
    output logic                  eq
);

    logic [CHAR_W-1:0]     letter_reg;
    logic [CHAR_W-1:0]     letter_next;
    logic [LEN_W-1:0]      pat_pos_full;
    logic [CELL_IDX_W-1:0] pat_pos;
    logic                  active;
    logic [CHAR_W-1:0]     pat_letter;

    // window entry j lines up with pattern letter len-1-j
    assign pat_pos_full = pattern_length - LEN_W'(1) - LEN_W'(cell_idx);
    assign pat_pos      = pat_pos_full[CELL_IDX_W-1:0];
    assign active       = LEN_W'(cell_idx) < pattern_length;
    assign pat_letter   = pattern[pat_pos*CHAR_W +: CHAR_W];

    // compare against the letter this cell holds after the shift
    assign eq = !active || (letter_in == pat_letter);

    always_comb begin
        letter_next = letter_reg;
        if (ctrl.clear) begin
            letter_next = '0;
        end else if (ctrl.shift) begin
            letter_next = letter_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            letter_reg <= '0;
        end else begin
            letter_reg <= letter_next;
        end
    end

    assign letter_out = letter_reg;

endmodule

### src/letter_filtered_substring_count.sv
// ----------------------------------------------------------------------------
// letter_filtered_substring_count
// Result: the count appears on m_ in the cycle after the word marked last is accepted.
// Throughput: one word per cycle while results are taken; cells compare in parallel.
// Reset: synchronous, active low; clears window, counters, pattern registers, m_valid.
// ----------------------------------------------------------------------------
module letter_filtered_substring_count
    import lfsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CHAR_W-1:0]    s_text_char,
    input  logic                 s_last_char,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COUNT_W-1:0]   m_match_count
);

    logic [LEN_W-1:0]   pattern_length_reg;
    logic [WORD_W-1:0]  pattern_word_reg [NUM_WORDS];
    pattern_t           pattern_flat;

    logic [SEEN_W-1:0]  seen_reg;
    logic [SEEN_W-1:0]  seen_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [COUNT_W-1:0] m_count_reg;
    logic [COUNT_W-1:0] m_count_next;

    logic               in_fire;
    logic               letter;
    logic               match;
    logic [SEEN_W-1:0]  seen_inc;
    logic [COUNT_W-1:0] count_inc;
    cell_ctrl_t         ctrl;

    logic [CHAR_W-1:0]      chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] eq_vec;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                pattern_word_reg[i] <= '0;
            end
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[LEN_W-1:0];
                CFG_PATTERN_WORD_0: pattern_word_reg[0] <= cfg_wdata;
                CFG_PATTERN_WORD_1: pattern_word_reg[1] <= cfg_wdata;
                CFG_PATTERN_WORD_2: pattern_word_reg[2] <= cfg_wdata;
                CFG_PATTERN_WORD_3: pattern_word_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_WORDS; i++) begin
            pattern_flat[i*WORD_W +: WORD_W] = pattern_word_reg[i];
        end
    end

    assign s_ready    = !m_valid_reg || m_ready;
    assign in_fire    = s_valid && s_ready;
    assign letter     = is_letter(s_text_char);
    assign ctrl.shift = in_fire && letter;
    assign ctrl.clear = in_fire && s_last_char;

    // row of window cells, newest letter enters at cell 0
    assign chain[0] = s_text_char;

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        lfsc_cell u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctrl           (ctrl),
            .cell_idx       (CELL_IDX_W'(j)),
            .pattern_length (pattern_length_reg),
            .pattern        (pattern_flat),
            .letter_in      (chain[j]),
            .letter_out     (chain[j+1]),
            .eq             (eq_vec[j])
        );
    end

    assign seen_inc = (seen_reg < SEEN_W'(MAX_PATTERN)) ? seen_reg + SEEN_W'(1) : seen_reg;

    // empty pattern matches every letter; an oversize one never does
    assign match = (pattern_length_reg == '0) ||
                   ((pattern_length_reg <= LEN_W'(MAX_PATTERN)) &&
                    (seen_inc >= pattern_length_reg) && (&eq_vec));

    assign count_inc = (match && (count_reg < COUNT_W'(COUNT_LIMIT))) ?
                       count_reg + COUNT_W'(1) : count_reg;

    always_comb begin
        seen_next    = seen_reg;
        count_next   = count_reg;
        m_count_next = m_count_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (in_fire) begin
            if (s_last_char) begin
                m_count_next = letter ? count_inc : count_reg;
                m_valid_next = 1'b1;
                seen_next    = '0;
                count_next   = '0;
            end else if (letter) begin
                seen_next  = seen_inc;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            seen_reg    <= seen_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_count_reg <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_match_count = m_count_reg;

`ifndef SYNTHESIS
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_last_char) |=> (seen_reg == '0) && (count_reg == '0))
        else $error("state not cleared after last word");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(COUNT_LIMIT))
        else $error("running count above limit");

    a_seen_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= SEEN_W'(MAX_PATTERN))
        else $error("letter counter above window depth");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_fire && s_last_char))
        else $error("result raised without a last word");
`endif

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds text words into letter_filtered_substring_count and checks each
// emitted match count against a cycle-free count predictor kept in this file.
// Covers reset defaults, letter boundaries, overlapping and dropped-byte
// matches, over-long patterns, saturation, output hold-off and random texts.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lfsc_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_WORDS   = 200;
    localparam int LETTERS_PER_WORD = WORD_W / CHAR_W;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wen     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [WORD_W-1:0]    cfg_wdata   = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [CHAR_W-1:0]    s_text_char = '0;
    logic                 s_last_char = 1'b0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [COUNT_W-1:0]   m_match_count;

    // predictor copy of registers and per-text state
    logic [LEN_W-1:0]   exp_pat_len;
    logic [WORD_W-1:0]  exp_pat_word [NUM_WORDS];
    logic [CHAR_W-1:0]  exp_window [MAX_PATTERN];
    int unsigned        exp_seen;
    int unsigned        exp_count;
    logic [COUNT_W-1:0] expected_counts [$];

    logic [CHAR_W-1:0]  text_buf [$];

    int errors          = 0;
    int counts_checked  = 0;
    int words_sent      = 0;
    int words_predicted = 0;
    int reg_writes      = 0;
    int send_idle_pct   = 30;
    int recv_idle_pct   = 86;
    int hold_requests   = 0;
    int holds_taken     = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;

    letter_filtered_substring_count i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_char   (s_text_char),
        .s_last_char   (s_last_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_count (m_match_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // count predictor
    // ------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] pattern_letter_at(input int i);
        return exp_pat_word[i / LETTERS_PER_WORD][(i % LETTERS_PER_WORD) * CHAR_W +: CHAR_W];
    endfunction

    function automatic bit pattern_at_window_end();
        int unsigned n;
        n = exp_pat_len;
        if (n == 0) return 1'b1;
        if (n > MAX_PATTERN || n > exp_seen) return 1'b0;
        // first pattern letter lines up with the oldest letter of the match
        for (int i = 0; i < n; i++) begin
            if (pattern_letter_at(i) != exp_window[n - 1 - i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_text_state();
        foreach (exp_window[k]) exp_window[k] = '0;
        exp_seen  = 0;
        exp_count = 0;
    endfunction

    function automatic void reset_predictor();
        exp_pat_len = '0;
        foreach (exp_pat_word[w]) exp_pat_word[w] = '0;
        clear_text_state();
    endfunction

    function automatic void predict_word(input logic [CHAR_W-1:0] c, input logic last);
        bit letter;
        letter = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                 (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
        if (letter) begin
            for (int k = MAX_PATTERN - 1; k > 0; k--) exp_window[k] = exp_window[k - 1];
            exp_window[0] = c;
            if (exp_seen < MAX_PATTERN) exp_seen++;
            if (pattern_at_window_end() && exp_count < COUNT_LIMIT) exp_count++;
        end
        if (last) begin
            expected_counts.push_back(exp_count[COUNT_W-1:0]);
            clear_text_state();
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_word(s_text_char, s_last_char);
            words_predicted++;
        end
    end

    // ------------------------------------------------------------------
    // result check
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_counts
        logic [COUNT_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected match_count %0d with no text pending", m_match_count);
            end else begin
                want = expected_counts.pop_front();
                counts_checked++;
                if (m_match_count !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("match_count mismatch: expected %0d, got %0d",
                                 want, m_match_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls plus requested long hold-offs
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_requests != holds_taken) begin
            holds_taken = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_char <= c;
        s_last_char <= last;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_text_buf();
        for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // block is idle once every accepted word is predicted and every count is back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (words_predicted != words_sent || expected_counts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [WORD_W-1:0] value);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        if (idx == CFG_PATTERN_LENGTH) exp_pat_len = value[LEN_W-1:0];
        else exp_pat_word[int'(idx) - int'(CFG_PATTERN_WORD_0)] = value;
        reg_writes++;
    endtask

    task automatic load_pattern(input logic [LEN_W-1:0] len, input pattern_t pat);
        wait_idle();
        write_reg(CFG_PATTERN_LENGTH, WORD_W'(len));
        for (int w = 0; w < NUM_WORDS; w++)
            write_reg(cfg_index_t'(int'(CFG_PATTERN_WORD_0) + w), pat[w * WORD_W +: WORD_W]);
    endtask

    // letters of s in the low bytes, junk above them
    function automatic pattern_t pack_pattern(input string s);
        pattern_t pat;
        for (int i = 0; i < MAX_PATTERN; i++)
            pat[i * CHAR_W +: CHAR_W] = (i < s.len()) ? s[i] : CHAR_W'($urandom_range(255));
        return pat;
    endfunction

    function automatic logic [CHAR_W-1:0] random_letter();
        int unsigned r;
        r = $urandom_range(51);
        return (r < 26) ? CHAR_W'(CHAR_UPPER_A + r) : CHAR_W'(CHAR_LOWER_A + r - 26);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // empty pattern after reset counts every letter; neighbors of the ranges drop out
        send_char(8'h00, 1'b0);
        send_char(8'h40, 1'b0);
        send_char(CHAR_UPPER_A, 1'b0);
        send_char(CHAR_UPPER_Z, 1'b0);
        send_char(8'h5B, 1'b0);
        send_char(8'h60, 1'b0);
        send_char(CHAR_LOWER_A, 1'b0);
        send_char(CHAR_LOWER_Z, 1'b0);
        send_char(8'h7B, 1'b0);
        send_char(8'hFF, 1'b1);
        // a text without letters, then a letter as the last word
        send_char(8'h80, 1'b1);
        send_char(8'h51, 1'b1);
    endtask

    task automatic test_directed_patterns();
        // overlapping matches, and a dropped byte inside a match
        load_pattern(3, pack_pattern("aba"));
        send_string("ab-aba");
        send_string("ABA");
        // longer than the window: never matches
        load_pattern(63, pack_pattern("aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa"));
        send_string("aaa");
        // a non-letter in the pattern can never be matched
        load_pattern(2, pack_pattern("a1"));
        send_string("a1a");
    endtask

    task automatic test_count_saturation();
        load_pattern(0, '1);
        for (int i = 0; i < COUNT_LIMIT + 6; i++) text_buf.push_back(random_letter());
        send_text_buf();
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        send_idle_pct = 0;
        hold_requests <= hold_requests + 1;
        // short texts keep results coming while the receiver holds off
        for (int t = 0; t < 24; t++) begin
            repeat ($urandom_range(3, 1)) text_buf.push_back(random_letter());
            send_text_buf();
        end
        wait_idle();
        send_idle_pct = 30;
    endtask

    task automatic load_random_pattern();
        logic [CHAR_W-1:0] alphabet [3];
        pattern_t          pat;
        int unsigned       len, pick, pos;
        for (int k = 0; k < 3; k++) alphabet[k] = random_letter();
        pick = $urandom_range(99);
        if (pick < 5) len = 0;
        else if (pick < 12) len = $urandom_range(63, 33);
        else if (pick < 22) len = MAX_PATTERN;
        else len = $urandom_range(6, 1);
        for (int i = 0; i < MAX_PATTERN; i++)
            pat[i * CHAR_W +: CHAR_W] = (i < len) ? alphabet[$urandom_range(2)]
                                                  : CHAR_W'($urandom_range(255));
        if (len > 0 && len <= MAX_PATTERN && $urandom_range(19) == 0) begin
            pos = $urandom_range(len - 1);
            pat[pos * CHAR_W +: CHAR_W] = 8'h2D;
        end
        load_pattern(LEN_W'(len), pat);
    endtask

    task automatic send_random_text();
        int unsigned target, pick, n;
        n = (exp_pat_len > MAX_PATTERN) ? MAX_PATTERN : exp_pat_len;
        target = ($urandom_range(9) == 0) ? $urandom_range(160, 60) : $urandom_range(30, 1);
        while (text_buf.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                // whole pattern copy, now and then split by a non-letter
                for (int i = 0; i < n; i++) begin
                    text_buf.push_back(pattern_letter_at(i));
                    if ($urandom_range(9) == 0) text_buf.push_back(CHAR_W'($urandom_range(8'h40)));
                end
            end else if (pick < 75) begin
                text_buf.push_back((n > 0) ? pattern_letter_at($urandom_range(n - 1))
                                           : random_letter());
            end else if (pick < 88) begin
                text_buf.push_back(random_letter());
            end else begin
                text_buf.push_back(CHAR_W'($urandom_range(255)));
            end
        end
        send_text_buf();
    endtask

    task automatic test_random_texts();
        int unsigned phase_start;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 86 : 0;
            recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 30 : 0;
            phase_start   = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                load_random_pattern();
                repeat ($urandom_range(8, 2)) send_random_text();
            end
        end
        wait_idle();
    endtask

    initial begin
        reset_predictor();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed_patterns();
        test_count_saturation();
        test_output_backpressure();
        test_random_texts();
        wait_idle();
        $display("covered %0d text words, %0d counts, %0d register writes",
                 words_sent, counts_checked, reg_writes);
        $display("incl. empty, over-long and non-letter patterns, saturation at %0d, hold-off",
                 COUNT_LIMIT);
        if (errors == 0 && expected_counts.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
src/lfsc_pkg.sv
src/lfsc_cell.sv
src/letter_filtered_substring_count.sv
sim/testbench.sv
